// File: hw/rtl/comf_pkg.sv
// Shared constants, types and helpers for the clock offset median filter.
package comf_pkg;

    localparam int WINDOW_SIZE = 32;
    localparam int IDX_W       = $clog2(WINDOW_SIZE);
    localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
    localparam int TS_W        = 64;
    localparam int RTT_W       = 63;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 63;
    localparam int REQ_W       = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DEV = 1'b0,
        REG_REQ     = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_CAND_RD,
        ST_CAND_CAP,
        ST_RANK,
        ST_PICK,
        ST_DEV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [TS_W-1:0] t0;
        logic [TS_W-1:0] t1;
        logic [TS_W-1:0] t2;
        logic [TS_W-1:0] t3;
    } stamps_t;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [RTT_W-1:0] rtt;
        logic [TS_W-1:0]  offset;
    } calc_res_t;

    // Ring slot at a given distance from the base slot.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= (IDX_W+1)'(WINDOW_SIZE))
            sum = sum - (IDX_W+1)'(WINDOW_SIZE);
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/comf_calc.sv
// Three-stage pipeline for round trip, offset and overflow checks of one exchange.
module comf_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  comf_pkg::stamps_t   stamps,
    output comf_pkg::calc_res_t res
);
    import comf_pkg::*;

    logic            v1_reg, v2_reg, v3_reg;
    logic            ok1_reg, ok2_reg, ok3_reg;
    logic [TS_W-1:0] cl_reg, sl_reg, h1_reg, h2_reg;
    logic [TS_W-1:0] rtt_reg, sum_reg, off_reg;
    logic [RTT_W-1:0] rtt3_reg;

    logic [TS_W-1:0] cl, sl, h1, h2, rtt, sum;
    logic [TS_W-1:0] ov_cl, ov_sl, ov_h1, ov_h2, ov_rtt, ov_sum;
    logic            ok1, ok2;

    always_comb
    begin
        cl     = stamps.t3 - stamps.t0;
        sl     = stamps.t2 - stamps.t1;
        h1     = stamps.t1 - stamps.t0;
        h2     = stamps.t2 - stamps.t3;
        ov_cl  = (stamps.t3 ^ stamps.t0) & (stamps.t3 ^ cl);
        ov_sl  = (stamps.t2 ^ stamps.t1) & (stamps.t2 ^ sl);
        ov_h1  = (stamps.t1 ^ stamps.t0) & (stamps.t1 ^ h1);
        ov_h2  = (stamps.t2 ^ stamps.t3) & (stamps.t2 ^ h2);
        ok1    = !ov_cl[TS_W-1] && !ov_sl[TS_W-1] && !ov_h1[TS_W-1] && !ov_h2[TS_W-1];
        rtt    = cl_reg - sl_reg;
        sum    = h1_reg + h2_reg;
        ov_rtt = (cl_reg ^ sl_reg) & (cl_reg ^ rtt);
        ov_sum = ~(h1_reg ^ h2_reg) & (h1_reg ^ sum);
        ok2    = ok1_reg && !ov_rtt[TS_W-1] && !rtt[TS_W-1] && !ov_sum[TS_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cl_reg   <= cl;
        sl_reg   <= sl;
        h1_reg   <= h1;
        h2_reg   <= h2;
        ok1_reg  <= ok1;
        rtt_reg  <= rtt;
        sum_reg  <= sum;
        ok2_reg  <= ok2;
        // Adding the sign bit before the arithmetic shift rounds toward zero.
        off_reg  <= TS_W'($signed(sum_reg + {{(TS_W-1){1'b0}}, sum_reg[TS_W-1]}) >>> 1);
        rtt3_reg <= rtt_reg[RTT_W-1:0];
        ok3_reg  <= ok2_reg;
    end

    assign res.valid  = v3_reg;
    assign res.ok     = ok3_reg;
    assign res.rtt    = rtt3_reg;
    assign res.offset = off_reg;

endmodule

// File: hw/rtl/clock_offset_median_filter.sv
// Top level: sample window memories, median search and window summary.
//
// Input transactions arrive on s_tvalid/s_tready. s_tuser is the action
// (0 submit a sample, 1 clear the window); s_tdata holds the four
// timestamps. Every input transaction yields exactly one result on
// m_tvalid/m_tready. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, and the
// block itself does not enforce it. A sample's median is found by ranking
// candidates one at a time, each rank a full walk of the window over a
// single read port of the offset memory, followed by one more walk for
// the minimum round trip and the deviation check.
// A new input is taken once the previous item is finished, even while its
// result still waits in the output register; if the receiver stalls, the
// next result waits until the held one is taken.
// Reset empties the window and restores the register defaults; the memories
// are not cleared, since only entries that hold samples are ever read.
module clock_offset_median_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // client_send_time, server_receive_time, server_send_time, client_receive_time
    input  logic [255:0]                         s_tdata,
    // action
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // accepted, min_round_trip, median_offset, stored_count, synced, zero pad
    output logic [135:0]                         m_tdata,
    input  logic                                 cfg_we,
    input  logic [comf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [comf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import comf_pkg::*;

    state_t state_reg, state_next;

    logic [RTT_W-1:0] max_dev_reg;
    logic [REQ_W-1:0] req_reg;

    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             pv_reg, pv_next;
    logic [CNT_W-1:0] less_reg, less_next;
    logic [CNT_W-1:0] eq_reg, eq_next;
    logic [TS_W-1:0]  cand_reg, cand_next;
    logic [TS_W-1:0]  med_reg, med_next;
    logic [RTT_W-1:0] min_reg, min_next;
    logic             first_reg, first_next;
    logic             stable_reg, stable_next;
    logic             acc_reg, acc_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [135:0]     m_tdata_reg, m_tdata_next;

    logic [TS_W-1:0]  off_mem [WINDOW_SIZE];
    logic [RTT_W-1:0] rtt_mem [WINDOW_SIZE];
    logic [TS_W-1:0]  off_rd_reg;
    logic [RTT_W-1:0] rtt_rd_reg;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr, rd_addr;

    logic             s_accept;
    stamps_t          stamps;
    calc_res_t        res;

    logic [CNT_W:0]   k_ext;
    logic [TS_W-1:0]  diff;
    logic             below;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stamps.t0 = s_tdata[63:0];
    assign stamps.t1 = s_tdata[127:64];
    assign stamps.t2 = s_tdata[191:128];
    assign stamps.t3 = s_tdata[255:192];

    comf_calc u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (s_accept && !s_tuser),
        .stamps (stamps),
        .res    (res)
    );

    // Writes happen only while the calculation completes; every read that is used comes later,
    // so no access to one entry can overlap another.
    assign wr_addr = slot_of(oldest_reg, fill_reg[IDX_W-1:0]);
    assign rd_addr = slot_of(oldest_reg, (state_reg == ST_CAND_RD) ? i_reg[IDX_W-1:0]
                                                                   : j_reg[IDX_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            off_mem[wr_addr] <= res.offset;
            rtt_mem[wr_addr] <= res.rtt;
        end
        off_rd_reg <= off_mem[rd_addr];
        rtt_rd_reg <= rtt_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dev_reg <= RTT_W'(5000);
            req_reg     <= REQ_W'(5);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_DEV: max_dev_reg <= cfg_data;
                REG_REQ:     req_reg     <= cfg_data[REQ_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            oldest_reg   <= '0;
            fill_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            fill_reg     <= fill_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            pv_reg       <= pv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        less_reg    <= less_next;
        eq_reg      <= eq_next;
        cand_reg    <= cand_next;
        med_reg     <= med_next;
        min_reg     <= min_next;
        first_reg   <= first_next;
        stable_reg  <= stable_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        oldest_next   = oldest_reg;
        fill_next     = fill_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pv_next       = pv_reg;
        less_next     = less_reg;
        eq_next       = eq_reg;
        cand_next     = cand_reg;
        med_next      = med_reg;
        min_next      = min_reg;
        first_next    = first_reg;
        stable_next   = stable_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;

        k_ext = {1'b0, fill_reg >> 1};
        below = $signed(off_rd_reg) < $signed(med_reg);
        diff  = below ? (med_reg - off_rd_reg) : (off_rd_reg - med_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    acc_next = 1'b0;
                    if (s_tuser)
                    begin
                        oldest_next = '0;
                        fill_next   = '0;
                        state_next  = ST_OUT;
                    end
                    else
                        state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (res.valid)
                begin
                    acc_next = res.ok;
                    i_next   = '0;
                    if (res.ok)
                    begin
                        mem_we = 1'b1;
                        if (fill_reg < CNT_W'(WINDOW_SIZE))
                            fill_next = fill_reg + CNT_W'(1);
                        else
                            oldest_next = slot_of(oldest_reg, IDX_W'(1));
                        state_next = ST_CAND_RD;
                    end
                    else if (fill_reg == '0)
                        state_next = ST_OUT;
                    else
                        state_next = ST_CAND_RD;
                end
            end
            ST_CAND_RD:
            begin
                state_next = ST_CAND_CAP;
            end
            ST_CAND_CAP:
            begin
                cand_next  = off_rd_reg;
                less_next  = '0;
                eq_next    = '0;
                j_next     = '0;
                pv_next    = 1'b0;
                state_next = ST_RANK;
            end
            ST_RANK, ST_DEV:
            begin
                if (j_reg < fill_reg)
                begin
                    j_next  = j_reg + CNT_W'(1);
                    pv_next = 1'b1;
                end
                else
                    pv_next = 1'b0;
                if (pv_reg)
                begin
                    if (state_reg == ST_RANK)
                    begin
                        if ($signed(off_rd_reg) < $signed(cand_reg))
                            less_next = less_reg + CNT_W'(1);
                        if (off_rd_reg == cand_reg)
                            eq_next = eq_reg + CNT_W'(1);
                    end
                    else
                    begin
                        if (first_reg || (rtt_rd_reg < min_reg))
                            min_next = rtt_rd_reg;
                        first_next = 1'b0;
                        if (diff > {1'b0, max_dev_reg})
                            stable_next = 1'b0;
                    end
                end
                else if (j_reg == fill_reg)
                    state_next = (state_reg == ST_RANK) ? ST_PICK : ST_OUT;
            end
            ST_PICK:
            begin
                // The candidate is the median when the middle position falls
                // within its run of equal values.
                if (({1'b0, less_reg} <= k_ext) &&
                    (k_ext < ({1'b0, less_reg} + {1'b0, eq_reg})))
                begin
                    med_next    = cand_reg;
                    j_next      = '0;
                    pv_next     = 1'b0;
                    first_next  = 1'b1;
                    stable_next = 1'b1;
                    state_next  = ST_DEV;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_CAND_RD;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0] = acc_reg;
                    if (fill_reg != '0)
                    begin
                        m_tdata_next[63:1]    = min_reg;
                        m_tdata_next[127:64]  = med_reg;
                        m_tdata_next[133:128] = fill_reg;
                        m_tdata_next[134]     = ({1'b0, fill_reg} >= {1'b0, req_reg}) &&
                                                stable_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
